// File: rtl/core/prr_pkg.sv
`default_nettype none
package prr_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_COEF = 9;
	localparam int PROD_W = 60;
	localparam int N2_W = 61;
	localparam int NUM_W = 63;
	localparam int MAG_W = 62;
	localparam int DIV_STEPS = 30;
	localparam logic [N2_W-1:0] N2_MIN = N2_W'(64'd1 << 26);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W  = 3'd0,
		REG_QUAT_X  = 3'd1,
		REG_QUAT_Y  = 3'd2,
		REG_QUAT_Z  = 3'd3,
		REG_TRANS_X = 3'd4,
		REG_TRANS_Y = 3'd5,
		REG_TRANS_Z = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ROT_IDLE,
		ROT_MUL,
		ROT_SUM,
		ROT_DSET,
		ROT_DSTEP
	} rot_state_t;

	typedef logic signed [31:0] coef_t;

	typedef struct packed {
		logic busy;
		logic degen;
	} rot_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/prr_rot.sv
`default_nettype none
module prr_rot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                kick,
	input  logic signed [31:0]  qw,
	input  logic signed [31:0]  qx,
	input  logic signed [31:0]  qy,
	input  logic signed [31:0]  qz,
	output prr_pkg::rot_stat_t  stat,
	output prr_pkg::coef_t      rot_m [prr_pkg::NUM_COEF]
);

	localparam int E_XX = 0;
	localparam int E_YY = 1;
	localparam int E_ZZ = 2;
	localparam int E_WW = 3;
	localparam int E_XY = 4;
	localparam int E_XZ = 5;
	localparam int E_YZ = 6;
	localparam int E_WX = 7;
	localparam int E_WY = 8;
	localparam int E_WZ = 9;
	localparam int NUM_E = 10;
	localparam logic [3:0] MUL_LAST = 4'(NUM_E - 1);
	localparam logic [3:0] ENT_LAST = 4'(prr_pkg::NUM_COEF - 1);
	localparam logic [4:0] STEP_LAST = 5'(prr_pkg::DIV_STEPS - 1);

	prr_pkg::rot_state_t state_q, state_d;
	logic [3:0] mul_cnt_q;
	logic [3:0] ent_cnt_q;
	logic [4:0] step_q;
	logic signed [prr_pkg::PROD_W-1:0] e_q [NUM_E];
	logic [prr_pkg::N2_W-1:0] n2_q;
	logic degen_q;
	logic neg_q;
	logic [prr_pkg::N2_W-1:0] rem_q;
	logic [30:0] quo_q;
	prr_pkg::coef_t r_q [prr_pkg::NUM_COEF];

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic [prr_pkg::N2_W-1:0] n2_sum;
	logic signed [prr_pkg::NUM_W-1:0] num;
	logic signed [prr_pkg::NUM_W-1:0] n2_s;
	logic [prr_pkg::MAG_W-1:0] mag;
	logic div_sat;
	logic ip_bit;
	logic [prr_pkg::MAG_W-1:0] rem2;
	logic rem_ge;
	logic [30:0] quo_nx;
	logic ent_last;

	always_comb begin
		unique case (mul_cnt_q)
			4'd0: begin mul_a = qx; mul_b = qx; end
			4'd1: begin mul_a = qy; mul_b = qy; end
			4'd2: begin mul_a = qz; mul_b = qz; end
			4'd3: begin mul_a = qw; mul_b = qw; end
			4'd4: begin mul_a = qx; mul_b = qy; end
			4'd5: begin mul_a = qx; mul_b = qz; end
			4'd6: begin mul_a = qy; mul_b = qz; end
			4'd7: begin mul_a = qw; mul_b = qx; end
			4'd8: begin mul_a = qw; mul_b = qy; end
			4'd9: begin mul_a = qw; mul_b = qz; end
			default: begin mul_a = qx; mul_b = qx; end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);
	assign n2_sum = prr_pkg::N2_W'(e_q[E_XX]) + prr_pkg::N2_W'(e_q[E_YY])
		+ prr_pkg::N2_W'(e_q[E_ZZ]) + prr_pkg::N2_W'(e_q[E_WW]);
	assign n2_s = $signed({2'b00, n2_q});

	function automatic logic signed [prr_pkg::NUM_W-1:0] ext(
		input logic signed [prr_pkg::PROD_W-1:0] v);
		ext = prr_pkg::NUM_W'(v);
	endfunction

	always_comb begin
		unique case (ent_cnt_q)
			4'd0: num = n2_s - 2 * (ext(e_q[E_YY]) + ext(e_q[E_ZZ]));
			4'd1: num = 2 * (ext(e_q[E_XY]) - ext(e_q[E_WZ]));
			4'd2: num = 2 * (ext(e_q[E_XZ]) + ext(e_q[E_WY]));
			4'd3: num = 2 * (ext(e_q[E_XY]) + ext(e_q[E_WZ]));
			4'd4: num = n2_s - 2 * (ext(e_q[E_XX]) + ext(e_q[E_ZZ]));
			4'd5: num = 2 * (ext(e_q[E_YZ]) - ext(e_q[E_WX]));
			4'd6: num = 2 * (ext(e_q[E_XZ]) - ext(e_q[E_WY]));
			4'd7: num = 2 * (ext(e_q[E_YZ]) + ext(e_q[E_WX]));
			4'd8: num = n2_s - 2 * (ext(e_q[E_XX]) + ext(e_q[E_YY]));
			default: num = '0;
		endcase
	end

	// restoring divide: sign/magnitude setup, then one quotient bit a cycle
	assign mag = num[prr_pkg::NUM_W-1] ? prr_pkg::MAG_W'(-num) : prr_pkg::MAG_W'(num);
	assign div_sat = mag >= {n2_q, 1'b0};
	assign ip_bit = mag >= {1'b0, n2_q};
	assign rem2 = {rem_q, 1'b0};
	assign rem_ge = rem2 >= {1'b0, n2_q};
	assign quo_nx = {quo_q[29:0], rem_ge};
	assign ent_last = ent_cnt_q == ENT_LAST;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prr_pkg::ROT_IDLE: state_d = prr_pkg::ROT_IDLE;
			prr_pkg::ROT_MUL: begin
				if (mul_cnt_q == MUL_LAST) state_d = prr_pkg::ROT_SUM;
			end
			prr_pkg::ROT_SUM: begin
				state_d = (n2_sum < prr_pkg::N2_MIN) ? prr_pkg::ROT_IDLE : prr_pkg::ROT_DSET;
			end
			prr_pkg::ROT_DSET: begin
				if (!div_sat) state_d = prr_pkg::ROT_DSTEP;
				else if (ent_last) state_d = prr_pkg::ROT_IDLE;
			end
			prr_pkg::ROT_DSTEP: begin
				if (step_q == STEP_LAST)
					state_d = ent_last ? prr_pkg::ROT_IDLE : prr_pkg::ROT_DSET;
			end
			default: state_d = prr_pkg::ROT_IDLE;
		endcase
		if (kick) state_d = prr_pkg::ROT_MUL;
	end

	always_comb begin
		stat.busy = state_q != prr_pkg::ROT_IDLE;
		stat.degen = degen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prr_pkg::ROT_MUL;
			mul_cnt_q <= '0;
			ent_cnt_q <= '0;
			step_q <= '0;
			degen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (kick) begin
				mul_cnt_q <= '0;
			end else begin
				unique case (state_q)
					prr_pkg::ROT_MUL: mul_cnt_q <= mul_cnt_q + 4'd1;
					prr_pkg::ROT_SUM: begin
						ent_cnt_q <= '0;
						step_q <= '0;
						degen_q <= n2_sum < prr_pkg::N2_MIN;
					end
					prr_pkg::ROT_DSET: begin
						if (div_sat) ent_cnt_q <= ent_cnt_q + 4'd1;
						step_q <= '0;
					end
					prr_pkg::ROT_DSTEP: begin
						step_q <= step_q + 5'd1;
						if (step_q == STEP_LAST) ent_cnt_q <= ent_cnt_q + 4'd1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prr_pkg::ROT_MUL && !kick)
			e_q[mul_cnt_q] <= prr_pkg::PROD_W'(prod >>> 4);
		if (state_q == prr_pkg::ROT_SUM) n2_q <= n2_sum;
		if (state_q == prr_pkg::ROT_DSET && !kick) begin
			neg_q <= num[prr_pkg::NUM_W-1];
			rem_q <= prr_pkg::N2_W'(mag - (ip_bit ? {1'b0, n2_q} : '0));
			quo_q <= {30'd0, ip_bit};
			if (div_sat)
				r_q[ent_cnt_q] <= num[prr_pkg::NUM_W-1] ? -32'sh7fffffff : 32'sh7fffffff;
		end
		if (state_q == prr_pkg::ROT_DSTEP && !kick) begin
			rem_q <= prr_pkg::N2_W'(rem_ge ? rem2 - {1'b0, n2_q} : rem2);
			quo_q <= quo_nx;
			if (step_q == STEP_LAST)
				r_q[ent_cnt_q] <= neg_q ? -$signed({1'b0, quo_nx}) : $signed({1'b0, quo_nx});
		end
	end

	assign rot_m = r_q;

endmodule
`default_nettype wire

// File: rtl/core/pose_ray_residual_core.sv
`default_nettype none
// channel   | handshake                  | payload
// request   | start / busy               | point_*, origin_*, dir_*, last_item
// result    | result_strobe (no stall)   | residual_*, last_result
// config    | write_en                   | write_index, write_data
//
// One request per cycle while busy is low; each result comes out of the
// registered pipeline with one strobe cycle. After reset, and after any
// quaternion write, busy stays high while the rotation matrix is rebuilt:
// ten products, one sum, then nine entries each set up and divided bit by bit.
// Results cannot be held off, so the pipeline never stalls.
module pose_ray_residual_core #(
	parameter int DATA_WIDTH = prr_pkg::DATA_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_en,
	input  logic [prr_pkg::CFG_IDX_W-1:0]       write_index,
	input  logic [DATA_WIDTH-1:0]               write_data,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [DATA_WIDTH-1:0]        point_x,
	input  logic signed [DATA_WIDTH-1:0]        point_y,
	input  logic signed [DATA_WIDTH-1:0]        point_z,
	input  logic signed [DATA_WIDTH-1:0]        origin_x,
	input  logic signed [DATA_WIDTH-1:0]        origin_y,
	input  logic signed [DATA_WIDTH-1:0]        origin_z,
	input  logic signed [DATA_WIDTH-1:0]        dir_x,
	input  logic signed [DATA_WIDTH-1:0]        dir_y,
	input  logic signed [DATA_WIDTH-1:0]        dir_z,
	input  logic                                last_item,
	output logic                                result_strobe,
	output logic signed [DATA_WIDTH-1:0]        residual_x,
	output logic signed [DATA_WIDTH-1:0]        residual_y,
	output logic signed [DATA_WIDTH-1:0]        residual_z,
	output logic                                last_result
);

	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	function automatic logic signed [31:0] clamp32(input logic signed [DATA_WIDTH-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		if (e > 64'sd2147483647) clamp32 = 32'sh7fffffff;
		else if (e < -64'sd2147483648) clamp32 = 32'sh80000000;
		else clamp32 = e[31:0];
	endfunction

	logic signed [DATA_WIDTH-1:0] cfg_q [7];
	logic kick;
	prr_pkg::rot_stat_t rstat;
	prr_pkg::coef_t rot_m [prr_pkg::NUM_COEF];
	logic accept;

	always_comb begin
		kick = 1'b0;
		if (write_en) begin
			unique case (prr_pkg::cfg_reg_t'(write_index))
				prr_pkg::REG_QUAT_W, prr_pkg::REG_QUAT_X,
				prr_pkg::REG_QUAT_Y, prr_pkg::REG_QUAT_Z: kick = 1'b1;
				default: kick = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[prr_pkg::REG_QUAT_W] <= DATA_WIDTH'(64'd1 << 30);
			cfg_q[prr_pkg::REG_QUAT_X] <= '0;
			cfg_q[prr_pkg::REG_QUAT_Y] <= '0;
			cfg_q[prr_pkg::REG_QUAT_Z] <= '0;
			cfg_q[prr_pkg::REG_TRANS_X] <= '0;
			cfg_q[prr_pkg::REG_TRANS_Y] <= '0;
			cfg_q[prr_pkg::REG_TRANS_Z] <= '0;
		end else if (write_en) begin
			unique case (prr_pkg::cfg_reg_t'(write_index))
				prr_pkg::REG_QUAT_W:  cfg_q[prr_pkg::REG_QUAT_W] <= write_data;
				prr_pkg::REG_QUAT_X:  cfg_q[prr_pkg::REG_QUAT_X] <= write_data;
				prr_pkg::REG_QUAT_Y:  cfg_q[prr_pkg::REG_QUAT_Y] <= write_data;
				prr_pkg::REG_QUAT_Z:  cfg_q[prr_pkg::REG_QUAT_Z] <= write_data;
				prr_pkg::REG_TRANS_X: cfg_q[prr_pkg::REG_TRANS_X] <= write_data;
				prr_pkg::REG_TRANS_Y: cfg_q[prr_pkg::REG_TRANS_Y] <= write_data;
				prr_pkg::REG_TRANS_Z: cfg_q[prr_pkg::REG_TRANS_Z] <= write_data;
				default: ;
			endcase
		end
	end

	prr_rot u_rot (
		.clk    (clk),
		.arst_n (arst_n),
		.kick   (kick),
		.qw     (clamp32(cfg_q[prr_pkg::REG_QUAT_W])),
		.qx     (clamp32(cfg_q[prr_pkg::REG_QUAT_X])),
		.qy     (clamp32(cfg_q[prr_pkg::REG_QUAT_Y])),
		.qz     (clamp32(cfg_q[prr_pkg::REG_QUAT_Z])),
		.stat   (rstat),
		.rot_m  (rot_m)
	);

	assign busy = rstat.busy;
	assign accept = start && !busy;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic l_s1, l_s2, l_s3, l_s4, l_s5, l_s6;
	logic signed [31:0] p_s1 [3];
	logic signed [31:0] o_s1 [3];
	logic signed [31:0] o_s2 [3];
	logic signed [31:0] dv_s1 [3];
	logic signed [31:0] dv_s2 [3];
	logic signed [31:0] dv_s3 [3];
	logic signed [61:0] pr_s2 [9];
	logic signed [37:0] d_s3 [3];
	logic signed [53:0] abh_s4 [3];
	logic signed [53:0] ceh_s4 [3];
	logic signed [48:0] abl_s4 [3];
	logic signed [48:0] cel_s4 [3];
	logic signed [54:0] hi_s5 [3];
	logic signed [49:0] lo_s5 [3];
	logic signed [DATA_WIDTH-1:0] res_s6 [3];

	logic signed [63:0] acc [3];
	logic signed [71:0] tot [3];
	logic signed [41:0] rnd [3];
	logic signed [63:0] rnd_x [3];
	logic signed [21:0] dh [3];
	logic signed [16:0] dl [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc[k] = 64'(pr_s2[k]) + 64'(pr_s2[3 + k]) + 64'(pr_s2[6 + k]);
			dh[k] = 22'(d_s3[k] >>> 16);
			dl[k] = $signed({1'b0, d_s3[k][15:0]});
			tot[k] = (72'(hi_s5[k]) <<< 16) + 72'(lo_s5[k]) + 72'sd536870912;
			rnd[k] = 42'(tot[k] >>> 30);
			rnd_x[k] = 64'(rnd[k]);
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= clamp32(point_x);  p_s1[1] <= clamp32(point_y);  p_s1[2] <= clamp32(point_z);
		o_s1[0] <= clamp32(origin_x); o_s1[1] <= clamp32(origin_y); o_s1[2] <= clamp32(origin_z);
		dv_s1[0] <= clamp32(dir_x);   dv_s1[1] <= clamp32(dir_y);   dv_s1[2] <= clamp32(dir_z);
		l_s1 <= last_item;
		l_s2 <= l_s1; l_s3 <= l_s2; l_s4 <= l_s3; l_s5 <= l_s4; l_s6 <= l_s5;
		o_s2 <= o_s1;
		dv_s2 <= dv_s1;
		dv_s3 <= dv_s2;
		for (int j = 0; j < 3; j++) begin
			for (int k = 0; k < 3; k++) begin
				pr_s2[3 * j + k] <= 62'((64'(p_s1[j]) * 64'(rot_m[3 * j + k])) >>> 2);
			end
		end
		for (int k = 0; k < 3; k++) begin
			d_s3[k] <= 38'((acc[k] + 64'sd134217728) >>> 28)
				+ 38'(clamp32(cfg_q[prr_pkg::REG_TRANS_X + k])) - 38'(o_s2[k]);
		end
		// comp k: d[k+1]*dir[k+2] - d[k+2]*dir[k+1], d split at bit 16
		for (int k = 0; k < 3; k++) begin
			abh_s4[k] <= 54'(dh[(k + 1) % 3]) * 54'(dv_s3[(k + 2) % 3]);
			abl_s4[k] <= 49'(dl[(k + 1) % 3]) * 49'(dv_s3[(k + 2) % 3]);
			ceh_s4[k] <= 54'(dh[(k + 2) % 3]) * 54'(dv_s3[(k + 1) % 3]);
			cel_s4[k] <= 49'(dl[(k + 2) % 3]) * 49'(dv_s3[(k + 1) % 3]);
			hi_s5[k] <= 55'(abh_s4[k]) - 55'(ceh_s4[k]);
			lo_s5[k] <= 50'(abl_s4[k]) - 50'(cel_s4[k]);
			if (rstat.degen) res_s6[k] <= '0;
			else if (rnd_x[k] > SAT_HI) res_s6[k] <= SAT_HI[DATA_WIDTH-1:0];
			else if (rnd_x[k] < SAT_LO) res_s6[k] <= SAT_LO[DATA_WIDTH-1:0];
			else res_s6[k] <= rnd_x[k][DATA_WIDTH-1:0];
		end
	end

	assign result_strobe = v_s6;
	assign residual_x = res_s6[0];
	assign residual_y = res_s6[1];
	assign residual_z = res_s6[2];
	assign last_result = l_s6;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(accept, 6))
		else $error("result without matching request");
	a_kick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		kick |=> busy)
		else $error("quaternion write did not start rebuild");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && $past(rstat.degen) && !busy) |->
		(residual_x == '0 && residual_y == '0 && residual_z == '0))
		else $error("degenerate pose gave nonzero residual");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;

	localparam int DW = 32;

	typedef struct {
		logic signed [31:0] rx, ry, rz;
		logic               lst;
	} resid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic write_en = 1'b0;
	logic [prr_pkg::CFG_IDX_W-1:0] write_index = '0;
	logic [DW-1:0] write_data = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [DW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [DW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [DW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic last_item = 1'b0;
	logic result_strobe;
	logic signed [DW-1:0] residual_x, residual_y, residual_z;
	logic last_result;

	pose_ray_residual_core #(.DATA_WIDTH(DW)) dut (.*);

	longint pose_regs [7];
	resid_t expected_resid[$];
	int n_fail = 0;
	bit quiet = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint fl(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint rot_div(longint num, longint den);
		longint mag, ip, rem, q;
		bit neg;
		neg = num < 0;
		mag = neg ? -num : num;
		ip = mag / den;
		rem = mag % den;
		if (ip >= 2) begin
			q = 64'h7FFFFFFF;
		end else begin
			q = ip;
			for (int i = 0; i < 30; i++) begin
				rem = rem << 1;
				q = q << 1;
				if (rem >= den) begin
					rem -= den;
					q |= 1;
				end
			end
			if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
		end
		return neg ? -q : q;
	endfunction

	// (a*b - c*e) / 2^30 rounded half up; a, c < 2^36 so split to stay in 64 bits
	function automatic longint cross_round(longint a, longint b, longint c, longint e);
		longint ah, al, ch, cl, hi, lo, hh, hr, fr;
		ah = fl(a, 16); al = a - ah * 65536;
		ch = fl(c, 16); cl = c - ch * 65536;
		hi = ah * b - ch * e;
		lo = al * b - cl * e;
		hh = fl(hi, 14);
		hr = hi - hh * 16384;
		fr = hr * 65536 + lo + (64'sd1 <<< 29);
		return hh + fl(fr, 30);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic resid_t predict_residual(longint p[3], longint o[3], longint dv[3],
			logic lst);
		resid_t r;
		longint w, x, y, z, exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz, n2, acc;
		longint m[3][3];
		longint d[3];
		w = pose_regs[0]; x = pose_regs[1]; y = pose_regs[2]; z = pose_regs[3];
		r.lst = lst;
		exx = fl(x * x, 4); eyy = fl(y * y, 4); ezz = fl(z * z, 4); eww = fl(w * w, 4);
		exy = fl(x * y, 4); exz = fl(x * z, 4); eyz = fl(y * z, 4);
		ewx = fl(w * x, 4); ewy = fl(w * y, 4); ewz = fl(w * z, 4);
		n2 = exx + eyy + ezz + eww;
		if (n2 < (64'sd1 <<< 26)) begin
			r.rx = 0; r.ry = 0; r.rz = 0;
			return r;
		end
		m[0][0] = rot_div(n2 - 2 * (eyy + ezz), n2);
		m[0][1] = rot_div(2 * (exy - ewz), n2);
		m[0][2] = rot_div(2 * (exz + ewy), n2);
		m[1][0] = rot_div(2 * (exy + ewz), n2);
		m[1][1] = rot_div(n2 - 2 * (exx + ezz), n2);
		m[1][2] = rot_div(2 * (eyz - ewx), n2);
		m[2][0] = rot_div(2 * (exz - ewy), n2);
		m[2][1] = rot_div(2 * (eyz + ewx), n2);
		m[2][2] = rot_div(n2 - 2 * (exx + eyy), n2);
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) acc += fl(p[j] * m[j][k], 2);
			d[k] = fl(acc + (64'sd1 <<< 27), 28) + pose_regs[4 + k] - o[k];
		end
		r.rx = sat32(cross_round(d[1], dv[2], d[2], dv[1]));
		r.ry = sat32(cross_round(d[2], dv[0], d[0], dv[2]));
		r.rz = sat32(cross_round(d[0], dv[1], d[1], dv[0]));
		return r;
	endfunction

	always @(posedge clk) begin
		resid_t e;
		if (result_strobe) begin
			if (expected_resid.size() == 0) begin
				$error("residual with none expected");
				n_fail++;
			end else begin
				e = expected_resid.pop_front();
				if (residual_x !== e.rx) begin
					$error("residual_x exp %0d got %0d", e.rx, residual_x); n_fail++;
				end
				if (residual_y !== e.ry) begin
					$error("residual_y exp %0d got %0d", e.ry, residual_y); n_fail++;
				end
				if (residual_z !== e.rz) begin
					$error("residual_z exp %0d got %0d", e.rz, residual_z); n_fail++;
				end
				if (last_result !== e.lst) begin
					$error("last_result exp %0b got %0b", e.lst, last_result); n_fail++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (expected_resid.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_pose(prr_pkg::cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= val;
		pose_regs[idx] = longint'(signed'(val));
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	task automatic set_pose(logic [31:0] qw, qx, qy, qz, tx, ty, tz);
		wait_drained();
		write_pose(prr_pkg::REG_QUAT_W, qw);
		write_pose(prr_pkg::REG_QUAT_X, qx);
		write_pose(prr_pkg::REG_QUAT_Y, qy);
		write_pose(prr_pkg::REG_QUAT_Z, qz);
		write_pose(prr_pkg::REG_TRANS_X, tx);
		write_pose(prr_pkg::REG_TRANS_Y, ty);
		write_pose(prr_pkg::REG_TRANS_Z, tz);
	endtask

	// one ray request; called at a falling edge, returns at a falling edge
	task automatic send_ray(logic [31:0] f[9], logic lst);
		longint p[3], o[3], dv[3];
		if (!quiet && $urandom_range(99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		{point_x, point_y, point_z} <= {f[0], f[1], f[2]};
		{origin_x, origin_y, origin_z} <= {f[3], f[4], f[5]};
		{dir_x, dir_y, dir_z} <= {f[6], f[7], f[8]};
		last_item <= lst;
		for (int k = 0; k < 3; k++) begin
			p[k] = longint'(signed'(f[k]));
			o[k] = longint'(signed'(f[3 + k]));
			dv[k] = longint'(signed'(f[6 + k]));
		end
		do @(posedge clk); while (busy);
		expected_resid = {expected_resid, predict_residual(p, o, dv, lst)};
		@(negedge clk);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
	endtask

	function automatic logic [31:0] rnd_val();
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 65535) - 32768;
			3: return ($urandom_range(0, 2047) - 1024) << 16;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rnd_dir();
		case ($urandom_range(3))
			0: return 32'h40000000;
			1: return 32'hC0000000;
			default: return ($urandom_range(0, 32'h7FFFFFFF) >>> 1) - 32'h20000000;
		endcase
	endfunction

	task automatic send_random_pair();
		logic [31:0] f[9];
		bit lst;
		for (int k = 0; k < 6; k++) f[k] = rnd_val();
		for (int k = 6; k < 9; k++) f[k] = rnd_dir();
		lst = $urandom_range(15) == 0;
		send_ray(f, 1'b0);
		for (int k = 3; k < 9; k++) f[k] = (k < 6) ? rnd_val() : rnd_dir();
		send_ray(f, lst);
	endtask

	task automatic test_extremes();
		logic [31:0] f[9];
		logic [31:0] ext[4] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
		for (int i = 0; i < 4; i++) begin
			foreach (f[k]) f[k] = ext[i];
			send_ray(f, i[0]);
		end
		f = '{32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 32'h40000000, 0, 0};
		send_ray(f, 1'b1);
		stop_sending();
	endtask

	task automatic test_rotations();
		set_pose(32'h2D413CCD, 32'h2D413CCD, 0, 0, 32'h10000, 32'hFFFF0000, 32'h50000);
		repeat (6) send_random_pair();
		stop_sending();
		// negated quaternion must rotate the same way
		set_pose(32'hD2BEC333, 32'hD2BEC333, 0, 0, 32'h10000, 32'hFFFF0000, 32'h50000);
		repeat (6) send_random_pair();
		stop_sending();
		set_pose(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		repeat (4) send_random_pair();
		stop_sending();
	endtask

	task automatic test_degenerate();
		set_pose(0, 0, 0, 0, 32'h10000, 0, 0);
		repeat (3) send_random_pair();
		stop_sending();
		// squared norm well under the N2_MIN degenerate threshold
		set_pose(32'h00000FFF, 32'h00000FFF, 0, 0, 0, 0, 0);
		repeat (2) send_random_pair();
		stop_sending();
	endtask

	task automatic test_random_poses();
		for (int ph = 0; ph < 12; ph++) begin
			set_pose($urandom, $urandom, $urandom, $urandom, rnd_val(), rnd_val(), rnd_val());
			if (ph == 3) quiet = 1;
			if (ph == 5) quiet = 0;
			repeat (40) send_random_pair();
			stop_sending();
			if (ph == 7) begin
				wait_drained();
			end
		end
		stop_sending();
	endtask

	initial begin
		pose_regs = '{64'sd1 <<< 30, 0, 0, 0, 0, 0, 0};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_rotations();
		test_degenerate();
		test_random_poses();
		wait_drained();
		repeat (20) @(posedge clk);
		if (n_fail == 0 && expected_resid.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/prr_pkg.sv
rtl/core/prr_rot.sv
rtl/core/pose_ray_residual_core.sv
verif/testbench.sv
